@@ rtl/wmm_pkg.sv @@
// Package for the 3x3 window mean and median unit.
// Holds the pixel width, the window constants and the request and result structs.
// Depends on nothing.
`timescale 1ns / 1ps
package wmm_pkg;

  localparam int PIX_BITS = 8;
  localparam int WIN_SIZE = 9;
  localparam int ROW_SUM_BITS = PIX_BITS + 2;
  localparam int SUM_BITS = PIX_BITS + 4;
  localparam int PIPE_DEPTH = 4;

  typedef logic [PIX_BITS-1:0] pix_t;

  typedef struct packed {
    pix_t pix_0;
    pix_t pix_1;
    pix_t pix_2;
    pix_t pix_3;
    pix_t pix_4;
    pix_t pix_5;
    pix_t pix_6;
    pix_t pix_7;
    pix_t pix_8;
  } wmm_in_t;

  typedef struct packed {
    pix_t mean_out;
    pix_t median_out;
  } wmm_out_t;

endpackage

@@ rtl/wmm_median.sv @@
// Four-stage median-of-nine network: row sorts, column selects, final median, output register.
// Depends on wmm_pkg.
`timescale 1ns / 1ps
module wmm_median
  import wmm_pkg::*;
(
  input  logic    clk,
  input  wmm_in_t win,
  output pix_t    median
);

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  pix_t lo_nxt [3];
  pix_t md_nxt [3];
  pix_t hi_nxt [3];
  pix_t lo_r [3];
  pix_t md_r [3];
  pix_t hi_r [3];
  pix_t row_a [3];
  pix_t row_b [3];
  pix_t row_c [3];
  pix_t sel_lo_nxt, sel_md_nxt, sel_hi_nxt;
  pix_t sel_lo_r, sel_md_r, sel_hi_r;
  pix_t med_nxt, med_r, med_out_r;

  assign row_a[0] = win.pix_0;
  assign row_b[0] = win.pix_1;
  assign row_c[0] = win.pix_2;
  assign row_a[1] = win.pix_3;
  assign row_b[1] = win.pix_4;
  assign row_c[1] = win.pix_5;
  assign row_a[2] = win.pix_6;
  assign row_b[2] = win.pix_7;
  assign row_c[2] = win.pix_8;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_nxt[i] = min2(min2(row_a[i], row_b[i]), row_c[i]);
      md_nxt[i] = med3(row_a[i], row_b[i], row_c[i]);
      hi_nxt[i] = max2(max2(row_a[i], row_b[i]), row_c[i]);
    end
  end

  assign sel_lo_nxt = max2(max2(lo_r[0], lo_r[1]), lo_r[2]);
  assign sel_md_nxt = med3(md_r[0], md_r[1], md_r[2]);
  assign sel_hi_nxt = min2(min2(hi_r[0], hi_r[1]), hi_r[2]);
  assign med_nxt = med3(sel_lo_r, sel_md_r, sel_hi_r);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      lo_r[i] <= lo_nxt[i];
      md_r[i] <= md_nxt[i];
      hi_r[i] <= hi_nxt[i];
    end
    sel_lo_r  <= sel_lo_nxt;
    sel_md_r  <= sel_md_nxt;
    sel_hi_r  <= sel_hi_nxt;
    med_r     <= med_nxt;
    med_out_r <= med_r;
  end

  assign median = med_out_r;

endmodule

@@ rtl/wmm_mean.sv @@
// Four-stage mean of nine pixels: row sums, total, reciprocal product, quotient correction.
// Depends on wmm_pkg.
`timescale 1ns / 1ps
module wmm_mean
  import wmm_pkg::*;
(
  input  logic    clk,
  input  wmm_in_t win,
  output pix_t    mean
);

  localparam int SHIFT = SUM_BITS + 1;
  localparam int PROD_BITS = SUM_BITS + SHIFT;
  localparam int REM_BITS = SUM_BITS + 4;
  localparam logic [PROD_BITS-1:0] RECIP = PROD_BITS'((2 ** SHIFT) / WIN_SIZE);

  logic [ROW_SUM_BITS-1:0] row_sum_nxt [3];
  logic [ROW_SUM_BITS-1:0] row_sum_r [3];
  logic [SUM_BITS-1:0]     sum_nxt, sum2_r, sum3_r;
  logic [PROD_BITS-1:0]    prod_nxt, prod_r;
  logic [SUM_BITS-1:0]     quo;
  logic [REM_BITS-1:0]     nine_quo, rem;
  logic [SUM_BITS-1:0]     quo_fix;
  pix_t                    mean_nxt, mean_r;

  assign row_sum_nxt[0] = ROW_SUM_BITS'(win.pix_0) + ROW_SUM_BITS'(win.pix_1)
                        + ROW_SUM_BITS'(win.pix_2);
  assign row_sum_nxt[1] = ROW_SUM_BITS'(win.pix_3) + ROW_SUM_BITS'(win.pix_4)
                        + ROW_SUM_BITS'(win.pix_5);
  assign row_sum_nxt[2] = ROW_SUM_BITS'(win.pix_6) + ROW_SUM_BITS'(win.pix_7)
                        + ROW_SUM_BITS'(win.pix_8);

  assign sum_nxt = SUM_BITS'(row_sum_r[0]) + SUM_BITS'(row_sum_r[1])
                 + SUM_BITS'(row_sum_r[2]);

  assign prod_nxt = PROD_BITS'(sum2_r) * RECIP;

  // The reciprocal is rounded down, so the estimate is short by at most one.
  assign quo      = prod_r[PROD_BITS-1:SHIFT];
  assign nine_quo = (REM_BITS'(quo) << 3) + REM_BITS'(quo);
  assign rem      = REM_BITS'(sum3_r) - nine_quo;
  assign quo_fix  = (rem >= REM_BITS'(WIN_SIZE)) ? quo + SUM_BITS'(1) : quo;
  assign mean_nxt = quo_fix[PIX_BITS-1:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      row_sum_r[i] <= row_sum_nxt[i];
    end
    sum2_r <= sum_nxt;
    sum3_r <= sum2_r;
    prod_r <= prod_nxt;
    mean_r <= mean_nxt;
  end

  assign mean = mean_r;

endmodule

@@ rtl/window_mean_median_3x3_unit.sv @@
// Top level of the 3x3 window mean and median unit.
// Depends on wmm_pkg, wmm_mean and wmm_median.
//
//   channel   ports                        handshake
//   request   start, busy, in_data         taken when start is high and busy is low
//   result    out_valid, out_data          one-cycle strobe, no back-pressure
//
// Each request gives one result, and results leave in the order the requests were taken.
// A new request can be taken in every cycle; the four register stages of
// the median network and of the mean divider set the latency.
// Reset is synchronous and active low; it clears the valid bits, and busy
// is high only while reset is applied. The receiver cannot stall the unit.
`timescale 1ns / 1ps
module window_mean_median_3x3_unit
  import wmm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  wmm_in_t  in_data,
  output logic     out_valid,
  output wmm_out_t out_data
);

  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;
  logic                  accept;
  pix_t                  mean, median;

  assign busy    = !rst_n;
  assign accept  = start && !busy;
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  wmm_mean u_mean (
    .clk  (clk),
    .win  (in_data),
    .mean (mean)
  );

  wmm_median u_median (
    .clk    (clk),
    .win    (in_data),
    .median (median)
  );

  assign out_valid           = vld_r[PIPE_DEPTH-1];
  assign out_data.mean_out   = mean;
  assign out_data.median_out = median;

endmodule

@@ rtl/wmm_checker.sv @@
// Port-level checks for the 3x3 window mean and median unit, bound to the top level.
// Depends on wmm_pkg and window_mean_median_3x3_unit.
`timescale 1ns / 1ps
module wmm_port_checker
  import wmm_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input wmm_in_t  in_data,
  input logic     out_valid,
  input wmm_out_t out_data
);

  localparam pix_t PIX_MAX = '1;

  logic acc;
  logic all_eq;
  logic low_zero;
  logic high_max;

  assign acc = start && !busy;
  assign all_eq = (in_data.pix_1 == in_data.pix_0) && (in_data.pix_2 == in_data.pix_0)
               && (in_data.pix_3 == in_data.pix_0) && (in_data.pix_4 == in_data.pix_0)
               && (in_data.pix_5 == in_data.pix_0) && (in_data.pix_6 == in_data.pix_0)
               && (in_data.pix_7 == in_data.pix_0) && (in_data.pix_8 == in_data.pix_0);
  assign low_zero = (in_data.pix_0 == '0) && (in_data.pix_1 == '0) && (in_data.pix_2 == '0)
                 && (in_data.pix_3 == '0) && (in_data.pix_4 == '0);
  assign high_max = (in_data.pix_4 == PIX_MAX) && (in_data.pix_5 == PIX_MAX)
                 && (in_data.pix_6 == PIX_MAX) && (in_data.pix_7 == PIX_MAX)
                 && (in_data.pix_8 == PIX_MAX);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(acc, PIPE_DEPTH))
    else $error("Result strobe does not follow a request by the pipeline latency.");

  a_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(acc && all_eq, PIPE_DEPTH) |->
      (out_data.mean_out == $past(in_data.pix_0, PIPE_DEPTH))
      && (out_data.median_out == $past(in_data.pix_0, PIPE_DEPTH)))
    else $error("A flat window did not return its own value.");

  a_low_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(acc && low_zero, PIPE_DEPTH) |-> out_data.median_out == '0)
    else $error("Five zero pixels did not give a zero median.");

  a_high_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(acc && high_max, PIPE_DEPTH) |-> out_data.median_out == PIX_MAX)
    else $error("Five full-scale pixels did not give a full-scale median.");

endmodule

bind window_mean_median_3x3_unit wmm_port_checker u_wmm_port_checker (.*);

@@ sim/wmm_checker.sv @@
// Checker for the 3x3 window mean and median unit: watches both channels,
// predicts the mean and median of every accepted request and compares results.
// Depends on wmm_pkg.
`timescale 1ns / 1ps
module wmm_checker
  import wmm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  wmm_in_t  in_data,
  input  logic     out_valid,
  input  wmm_out_t out_data,
  output int       fail_count,
  output int       pending_results
);

  localparam int MEDIAN_RANK = WIN_SIZE / 2;

  wmm_out_t expected_stats[$];
  wmm_out_t oldest;

  function automatic wmm_out_t window_stats(input wmm_in_t w);
    pix_t        px[WIN_SIZE];
    pix_t        key;
    int unsigned total;
    int          i;
    int          j;
    wmm_out_t    r;
    px[0] = w.pix_0;
    px[1] = w.pix_1;
    px[2] = w.pix_2;
    px[3] = w.pix_3;
    px[4] = w.pix_4;
    px[5] = w.pix_5;
    px[6] = w.pix_6;
    px[7] = w.pix_7;
    px[8] = w.pix_8;
    total = 0;
    for (i = 0; i < WIN_SIZE; i++) begin
      total += px[i];
    end
    for (i = 1; i < WIN_SIZE; i++) begin
      key = px[i];
      j = i;
      while (j > 0 && px[j-1] > key) begin
        px[j] = px[j-1];
        j--;
      end
      px[j] = key;
    end
    r.mean_out = pix_t'(total / WIN_SIZE);
    r.median_out = px[MEDIAN_RANK];
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_stats.size() == 0) begin
          $error("result with no request waiting: mean_out %0d, median_out %0d",
                 out_data.mean_out, out_data.median_out);
          fail_count++;
        end else begin
          oldest = expected_stats.pop_front();
          if (out_data.mean_out !== oldest.mean_out) begin
            $error("mean_out: expected %0d, actual %0d", oldest.mean_out, out_data.mean_out);
            fail_count++;
          end
          if (out_data.median_out !== oldest.median_out) begin
            $error("median_out: expected %0d, actual %0d",
                   oldest.median_out, out_data.median_out);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_stats.push_back(window_stats(in_data));
      end
      pending_results = expected_stats.size();
    end
  end

endmodule

@@ sim/tb.sv @@
// Testbench top for the 3x3 window mean and median unit: drives directed and
// random window requests with varying gaps and gives the verdict.
// Depends on wmm_pkg, window_mean_median_3x3_unit and wmm_checker.
`timescale 1ns / 1ps
module tb;
  import wmm_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS = 420;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  wmm_in_t  in_data;
  logic     out_valid;
  wmm_out_t out_data;
  int       fail_count;
  int       pending_results;
  int       idle_cycles;

  window_mean_median_3x3_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  wmm_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic wmm_in_t random_window();
    wmm_in_t w;
    pix_t    a;
    pix_t    b;
    pix_t    c;
    pix_t    v;
    int      kind;
    int      k;
    kind = $urandom_range(9);
    a = pix_t'($urandom);
    b = pix_t'($urandom);
    c = pix_t'($urandom);
    for (k = 0; k < WIN_SIZE; k++) begin
      case (kind)
        6: begin
          case ($urandom_range(2))
            0: v = a;
            1: v = b;
            default: v = c;
          endcase
        end
        7: begin
          case ($urandom_range(3))
            0: v = '0;
            1: v = pix_t'(1);
            2: v = '1;
            default: v = pix_t'((1 << PIX_BITS) - 2);
          endcase
        end
        8: begin
          v = a;
        end
        9: begin
          v = ($urandom_range(1) == 1) ? a : pix_t'($urandom);
        end
        default: begin
          v = pix_t'($urandom);
        end
      endcase
      w[(WIN_SIZE-1-k)*PIX_BITS +: PIX_BITS] = v;
    end
    return w;
  endfunction

  task automatic send_window(input wmm_in_t w, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      in_data <= random_window();
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic run_random_phase(input int idle_pct);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      send_window(random_window(), idle_pct);
    end
  endtask

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    send_window({9{8'h00}}, 0);
    send_window({9{8'hFF}}, 0);
    send_window({8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8}, 0);
    send_window({8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0}, 0);
    send_window({8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00}, 0);
    send_window({8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF}, 0);
    send_window({8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}, 0);
    send_window({8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}, 0);
    send_window({{8{8'd1}}, 8'd0}, 0);
    send_window({{8{8'd2}}, 8'd1}, 0);
    send_window({{8{8'hFE}}, 8'hFF}, 0);
    send_window({{4{8'd10}}, 8'd200, {4{8'd10}}}, 0);
    send_window({8'd9, 8'd1, 8'd8, 8'd2, 8'd7, 8'd3, 8'd6, 8'd4, 8'd5}, 0);
    send_window({8'd50, 8'd10, 8'd20, 8'd30, 8'd40, 8'd60, 8'd70, 8'd80, 8'd90}, 0);
    send_window({8'd90, 8'd10, 8'd20, 8'd30, 8'd40, 8'd60, 8'd70, 8'd80, 8'd50}, 0);
    send_window({8'd3, 8'd3, 8'd3, 8'd3, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7}, 0);
    send_window({8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h00}, 0);

    run_random_phase(8);
    run_random_phase(64);
    run_random_phase(0);

    @(negedge clk);
    start <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
